### hdl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/dpd_pkg.sv
// Types, codes and helpers for the debug packet deframer.
`timescale 1ns / 1ps

package dpd_pkg;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_HI   = 3'd3,
        PH_LO   = 3'd4,
        PH_FULL = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        EV_BYTE     = 3'd0,
        EV_GOOD     = 3'd1,
        EV_BAD      = 3'd2,
        EV_RESTART  = 3'd3,
        EV_OVERFLOW = 3'd4
    } event_t;

    localparam logic [7:0] CH_START  = 8'h24;  // '$'
    localparam logic [7:0] CH_END    = 8'h23;  // '#'
    localparam logic [7:0] ESC_XOR   = 8'h20;
    localparam logic [7:0] ESC_RESET = 8'd125; // '}'
    localparam int         POS_W     = 10;

    // Hex digit decode: {bad, nibble}.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        begin
            if (c >= 8'h30 && c <= 8'h39) begin
                r = {1'b0, 4'(c - 8'h30)};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                r = {1'b0, 4'(c - 8'h57)};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                r = {1'b0, 4'(c - 8'h37)};
            end else begin
                r = 5'b10000;
            end
            return r;
        end
    endfunction

endpackage

### hdl/debug_packet_deframer.sv
// Debug packet deframer: '$'...'#xx' framing, unescape and checksum check.
`timescale 1ns / 1ps
// Usage
//   Input channel in_valid/in_ready/rx_byte carries one received link byte
//   per transfer. Output channel out_valid/out_ready carries event_res,
//   data, position and checksum; each input byte yields zero or one result.
//   Results: payload byte (with index and running sum), packet good,
//   checksum bad, restart discard (a '$' inside a packet), overflow.
//   cfg_valid/cfg_ready/escape_char writes the escape byte; cfg_ready is
//   always high. Write it only while the block is idle.
// Output timing and throughput
//   A result appears in the output register in the cycle after its input
//   transfer. One byte is taken every cycle while the output register is
//   empty or being drained in the same cycle; the single byte-step of
//   logic between the state registers and the result register sets this.
// Reset
//   rst_n low returns the deframer to hunting for '$', clears the sum,
//   count and digit state, empties the output register and sets the
//   escape byte to '}' (125).
// Stall
//   If the receiver holds out_ready low while a result is waiting,
//   in_ready drops and the result is held unchanged until it is taken.
module debug_packet_deframer #(
    parameter int BUFFER_SIZE = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] event_res,
    output logic [7:0] data,
    output logic [9:0] position,
    output logic [7:0] checksum,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] escape_char
);

    localparam int CNT_W     = $clog2(BUFFER_SIZE);
    localparam int CAPACITY  = BUFFER_SIZE - 2;
    localparam int POS_W_EXT = dpd_pkg::POS_W + CNT_W;

    // Packet state
    dpd_pkg::phase_t  phase_reg, phase_next;
    logic [7:0]       sum_reg, sum_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [3:0]       nib_reg, nib_next;
    logic             derr_reg, derr_next;
    logic [7:0]       esc_reg;

    // Result register
    logic             ovalid_reg, ovalid_next;
    dpd_pkg::event_t  ev_reg, ev_next;
    logic [7:0]       data_reg, data_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [7:0]       csum_reg, csum_next;

    logic             take;
    logic             emit;
    logic [4:0]       hex;
    logic [CNT_W:0]   count_inc;
    logic [7:0]       sum_add;
    logic [7:0]       store_val;
    logic [POS_W_EXT-1:0] pos_ext;

    assign in_ready  = !ovalid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign hex       = dpd_pkg::hex_decode(rx_byte);
    assign count_inc = {1'b0, count_reg} + (CNT_W + 1)'(1);
    assign sum_add   = sum_reg + rx_byte;
    assign store_val = (phase_reg == dpd_pkg::PH_ESC) ? (rx_byte ^ dpd_pkg::ESC_XOR)
                                                      : rx_byte;

    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        nib_next   = nib_reg;
        derr_next  = derr_reg;
        emit       = 1'b0;
        ev_next    = dpd_pkg::EV_BYTE;
        data_next  = 8'd0;
        pos_next   = count_reg;
        csum_next  = sum_reg;

        if (take) begin
            unique case (phase_reg)
                dpd_pkg::PH_BODY, dpd_pkg::PH_ESC:
                begin
                    if (phase_reg == dpd_pkg::PH_BODY && rx_byte == dpd_pkg::CH_START) begin
                        emit       = 1'b1;
                        ev_next    = dpd_pkg::EV_RESTART;
                        phase_next = dpd_pkg::PH_BODY;
                        sum_next   = 8'd0;
                        count_next = '0;
                        nib_next   = 4'd0;
                        derr_next  = 1'b0;
                    end else if (phase_reg == dpd_pkg::PH_BODY
                                 && rx_byte == dpd_pkg::CH_END) begin
                        phase_next = dpd_pkg::PH_HI;
                        derr_next  = 1'b0;
                    end else if (phase_reg == dpd_pkg::PH_BODY && rx_byte == esc_reg) begin
                        sum_next   = sum_add;
                        phase_next = dpd_pkg::PH_ESC;
                    end else begin
                        // payload byte
                        emit       = 1'b1;
                        ev_next    = dpd_pkg::EV_BYTE;
                        data_next  = store_val;
                        sum_next   = sum_add;
                        csum_next  = sum_add;
                        count_next = count_inc[CNT_W-1:0];
                        phase_next = (count_inc >= (CNT_W + 1)'(CAPACITY))
                                     ? dpd_pkg::PH_FULL : dpd_pkg::PH_BODY;
                    end
                end
                dpd_pkg::PH_HI:
                begin
                    nib_next   = hex[3:0];
                    derr_next  = derr_reg | hex[4];
                    phase_next = dpd_pkg::PH_LO;
                end
                dpd_pkg::PH_LO:
                begin
                    derr_next  = derr_reg | hex[4];
                    phase_next = dpd_pkg::PH_HUNT;
                    emit       = 1'b1;
                    if (!(derr_reg | hex[4]) && {nib_reg, hex[3:0]} == sum_reg) begin
                        ev_next = dpd_pkg::EV_GOOD;
                    end else begin
                        ev_next = dpd_pkg::EV_BAD;
                    end
                end
                dpd_pkg::PH_FULL, dpd_pkg::PH_HUNT:
                begin
                    if (phase_reg == dpd_pkg::PH_FULL) begin
                        emit    = 1'b1;
                        ev_next = dpd_pkg::EV_OVERFLOW;
                    end
                    if (rx_byte == dpd_pkg::CH_START) begin
                        phase_next = dpd_pkg::PH_BODY;
                        sum_next   = 8'd0;
                        count_next = '0;
                        nib_next   = 4'd0;
                        derr_next  = 1'b0;
                    end else begin
                        phase_next = dpd_pkg::PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = dpd_pkg::PH_HUNT;
                end
            endcase
        end

        // Output register: load on a result, drain on an output transfer.
        if (emit) begin
            ovalid_next = 1'b1;
        end else if (out_ready) begin
            ovalid_next = 1'b0;
        end else begin
            ovalid_next = ovalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= dpd_pkg::PH_HUNT;
            sum_reg    <= 8'd0;
            count_reg  <= '0;
            nib_reg    <= 4'd0;
            derr_reg   <= 1'b0;
            esc_reg    <= dpd_pkg::ESC_RESET;
            ovalid_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            nib_reg    <= nib_next;
            derr_reg   <= derr_next;
            ovalid_reg <= ovalid_next;
            if (cfg_valid && cfg_ready) begin
                esc_reg <= escape_char;
            end
        end
    end

    // Result payload, no reset needed.
    always_ff @(posedge clk)
    begin
        if (emit) begin
            ev_reg   <= ev_next;
            data_reg <= data_next;
            pos_reg  <= pos_next;
            csum_reg <= csum_next;
        end
    end

    assign pos_ext   = {{dpd_pkg::POS_W{1'b0}}, pos_reg};
    assign out_valid = ovalid_reg;
    assign event_res = ev_reg;
    assign data      = data_reg;
    assign position  = pos_ext[dpd_pkg::POS_W-1:0];
    assign checksum  = csum_reg;

endmodule

### hdl/dpd_checker.sv
// Port-level checker for the debug packet deframer, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dpd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] rx_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] event_res,
    input logic [7:0] data,
    input logic [9:0] position,
    input logic [7:0] checksum,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic [7:0] escape_char
);

    // A waiting result is held until taken.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(event_res) && $stable(data) && $stable(position) && $stable(checksum))

    // Only payload byte events carry data.
    `ASSERT_SAME(a_data_zero, clk, rst_n, out_valid && event_res != dpd_pkg::EV_BYTE, data == 8'd0)

    // A full result register blocks the input side.
    `ASSERT_SAME(a_backpressure, clk, rst_n, out_valid && !out_ready, !in_ready)

    // A new result follows an input transfer.
    `ASSERT_SAME(a_out_cause, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready))

endmodule

bind debug_packet_deframer dpd_checker u_dpd_checker (.*);
